### hw/rtl/ctb_pkg.sv
`timescale 1ns / 1ps

package ctb_pkg;

    localparam int MAX_DIM_DEF = 1024;

    localparam int SIZE_W     = 11;
    localparam int POS_W      = 12;
    localparam int TEXEL_W    = 8;
    localparam int ADDR_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Destination coordinates span a 12-bit position plus a counter of up to 11 bits.
    localparam int COORD_W = 14;

    localparam int SIZE_MAX = (2 ** SIZE_W) - 1;

    typedef struct packed {
        logic [SIZE_W-1:0]       buf_width;
        logic [SIZE_W-1:0]       buf_height;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       tex_width;
        logic [SIZE_W-1:0]       tex_height;
        logic                    transparent_mode;
    } ctb_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TEXEL_W-1:0]        texel;
        logic                      last;
    } ctb_point_t;

    // Texture sizes of zero behave as one; anything above the cap is held at the cap.
    function automatic logic [SIZE_W-1:0] clamp_tex(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > cap)
            r = cap;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_buf(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
        return (v > cap) ? cap : v;
    endfunction

endpackage

### hw/rtl/ctb_if.sv
`timescale 1ns / 1ps

interface ctb_texel_if;
    import ctb_pkg::*;

    logic               valid;
    logic               ready;
    logic [TEXEL_W-1:0] texel;

    modport source (output valid, output texel, input ready);
    modport sink (input valid, input texel, output ready);
endinterface

interface ctb_pixel_if;
    import ctb_pkg::*;

    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [ADDR_W-1:0]  write_address;
    logic [TEXEL_W-1:0] pixel_value;
    logic               last_texel;

    modport source (output valid, output write_enable, output write_address,
                    output pixel_value, output last_texel, input ready);
    modport sink (input valid, input write_enable, input write_address,
                  input pixel_value, input last_texel, output ready);
endinterface

### hw/rtl/clipped_transparent_blit_top.sv
`timescale 1ns / 1ps
// Each texel passes through one register that holds the destination coordinates and
// then one that holds the address and write flag before it is presented.
// Throughput: one texel per cycle while the pixel sink is ready; the multiply-add for the address sets the clock.
// Reset clears the column and row counters and both pipeline valid flags, and
// returns every configuration register to its default value.

module clipped_transparent_blit_top #(
    parameter int MAX_DIM = ctb_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctb_pkg::CFG_DATA_W-1:0] cfg_data,
    ctb_texel_if.sink                      texels,
    ctb_pixel_if.source                    pixels
);
    import ctb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_BUF_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 3'd6;

    ctb_cfg_t   cfg_reg, cfg_next;
    logic       pt_valid, pt_ready;
    ctb_point_t pt;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BUF_WIDTH:   cfg_next.buf_width        = cfg_data[SIZE_W-1:0];
                REG_BUF_HEIGHT:  cfg_next.buf_height       = cfg_data[SIZE_W-1:0];
                REG_POS_X:       cfg_next.pos_x            = signed'(cfg_data[POS_W-1:0]);
                REG_POS_Y:       cfg_next.pos_y            = signed'(cfg_data[POS_W-1:0]);
                REG_TEX_WIDTH:   cfg_next.tex_width        = cfg_data[SIZE_W-1:0];
                REG_TEX_HEIGHT:  cfg_next.tex_height       = cfg_data[SIZE_W-1:0];
                REG_TRANSPARENT: cfg_next.transparent_mode = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buf_width        <= SIZE_W'(320);
            cfg_reg.buf_height       <= SIZE_W'(200);
            cfg_reg.pos_x            <= '0;
            cfg_reg.pos_y            <= '0;
            cfg_reg.tex_width        <= SIZE_W'(1);
            cfg_reg.tex_height       <= SIZE_W'(1);
            cfg_reg.transparent_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ctb_walk #(
        .MAX_DIM (MAX_DIM)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .texels   (texels),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_ready (pt_ready)
    );

    ctb_pixel #(
        .MAX_DIM (MAX_DIM)
    ) u_pixel (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_ready (pt_ready),
        .pixels   (pixels)
    );

endmodule

### hw/rtl/ctb_walk.sv
`timescale 1ns / 1ps

module ctb_walk #(
    parameter int MAX_DIM = ctb_pkg::MAX_DIM_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctb_pkg::ctb_cfg_t cfg,
    ctb_texel_if.sink         texels,
    output logic              pt_valid,
    output ctb_pkg::ctb_point_t pt,
    input  logic              pt_ready
);
    import ctb_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'((MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             pt_valid_reg, pt_valid_next;
    ctb_point_t       pt_reg, pt_next;

    logic [SIZE_W-1:0] tw, th, tw_m1, th_m1;
    logic              row_end, col_end, accept;

    assign texels.ready = !pt_valid_reg || pt_ready;
    assign accept       = texels.valid && texels.ready;

    always_comb
    begin
        tw    = clamp_tex(cfg.tex_width, SIZE_CAP);
        th    = clamp_tex(cfg.tex_height, SIZE_CAP);
        tw_m1 = tw - SIZE_W'(1);
        th_m1 = th - SIZE_W'(1);

        // A counter left beyond a smaller new size ends its row or column at once.
        row_end = CMP_W'(row_reg) >= CMP_W'(th_m1);
        col_end = CMP_W'(col_reg) >= CMP_W'(tw_m1);

        pt_next.x = signed'(COORD_W'(cfg.pos_x)) + signed'(COORD_W'(col_reg));
        pt_next.y = signed'(COORD_W'(cfg.pos_y)) + signed'(COORD_W'(th_m1))
                    - signed'(COORD_W'(row_reg));
        pt_next.texel = texels.texel;
        pt_next.last  = row_end && col_end;

        col_next      = col_reg;
        row_next      = row_reg;
        pt_valid_next = pt_valid_reg;
        if (pt_ready)
            pt_valid_next = 1'b0;
        if (accept)
        begin
            pt_valid_next = 1'b1;
            if (row_end)
            begin
                row_next = '0;
                col_next = col_end ? '0 : col_reg + CNT_W'(1);
            end
            else
            begin
                row_next = row_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pt_valid_reg <= pt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pt_reg <= pt_next;
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

endmodule

### hw/rtl/ctb_pixel.sv
`timescale 1ns / 1ps

module ctb_pixel #(
    parameter int MAX_DIM = ctb_pkg::MAX_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctb_pkg::ctb_cfg_t   cfg,
    input  logic                pt_valid,
    input  ctb_pkg::ctb_point_t pt,
    output logic                pt_ready,
    ctb_pixel_if.source         pixels
);
    import ctb_pkg::*;

    localparam int PROD_W = 2 * SIZE_W;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'((MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM);

    logic               valid_reg, valid_next;
    logic               we_reg, we_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [TEXEL_W-1:0] value_reg;
    logic               last_reg;

    logic [SIZE_W-1:0] bw, bh;
    logic              in_buf, opaque, accept;
    logic [PROD_W-1:0] prod, sum;

    assign pt_ready = !valid_reg || pixels.ready;
    assign accept   = pt_valid && pt_ready;

    always_comb
    begin
        bw = clamp_buf(cfg.buf_width, SIZE_CAP);
        bh = clamp_buf(cfg.buf_height, SIZE_CAP);

        in_buf = !pt.x[COORD_W-1] && (pt.x < signed'(COORD_W'(bw)))
                 && !pt.y[COORD_W-1] && (pt.y < signed'(COORD_W'(bh)));
        opaque = !cfg.transparent_mode || (pt.texel != '0);
        we_next = in_buf && opaque;

        // Inside the buffer both coordinates fit the size width.
        prod = PROD_W'(pt.y[SIZE_W-1:0]) * PROD_W'(bw);
        sum  = prod + PROD_W'(pt.x[SIZE_W-1:0]);
        addr_next = we_next ? ADDR_W'(sum) : '0;

        valid_next = valid_reg;
        if (pixels.ready)
            valid_next = 1'b0;
        if (accept)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            we_reg    <= we_next;
            addr_reg  <= addr_next;
            value_reg <= pt.texel;
            last_reg  <= pt.last;
        end
    end

    assign pixels.valid         = valid_reg;
    assign pixels.write_enable  = we_reg;
    assign pixels.write_address = addr_reg;
    assign pixels.pixel_value   = value_reg;
    assign pixels.last_texel    = last_reg;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ctb_pkg::*;

    localparam int MAX_DIM               = MAX_DIM_DEF;
    localparam int QUIET_LIMIT           = 4000;
    localparam int RANDOM_ITEMS_PER_MODE = 575;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUF_WIDTH,
        REG_BUF_HEIGHT,
        REG_POS_X,
        REG_POS_Y,
        REG_TEX_WIDTH,
        REG_TEX_HEIGHT,
        REG_TRANSPARENT,
        REG_UNUSED
    } cfg_reg_e;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [TEXEL_W-1:0] pixel_value;
        logic               last_texel;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ctb_texel_if texels();
    ctb_pixel_if pixels();

    clipped_transparent_blit_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .texels   (texels),
        .pixels   (pixels)
    );

    // Shadow copy of the register file and the texture walk counters.
    logic [SIZE_W-1:0]       buf_width        = 11'd320;
    logic [SIZE_W-1:0]       buf_height       = 11'd200;
    logic signed [POS_W-1:0] pos_x            = '0;
    logic signed [POS_W-1:0] pos_y            = '0;
    logic [SIZE_W-1:0]       tex_width        = 11'd1;
    logic [SIZE_W-1:0]       tex_height       = 11'd1;
    logic                    transparent_mode = 1'b0;
    logic [9:0]              col_idx          = '0;
    logic [9:0]              row_idx          = '0;

    pixel_t pending_pixels[$];

    int errors            = 0;
    int src_idle_pct      = 0;
    int snk_idle_pct      = 0;
    int quiet_cycles      = 0;
    int texels_sent       = 0;
    int textures_done     = 0;
    int settings_used     = 0;
    int writes_enabled    = 0;
    int writes_suppressed = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int tex_extent(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int buf_extent(input logic [SIZE_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // Maps the texel at the current column and row to its destination and advances the walk.
    function automatic pixel_t blit_texel(input logic [TEXEL_W-1:0] texel);
        pixel_t p;
        int     tw;
        int     th;
        int     bw;
        int     bh;
        int     x;
        int     y;
        logic   in_buf;
        logic   opaque;
        logic   row_end;
        logic   col_end;
        tw = tex_extent(tex_width);
        th = tex_extent(tex_height);
        bw = buf_extent(buf_width);
        bh = buf_extent(buf_height);
        x = int'(pos_x) + int'(col_idx);
        y = int'(pos_y) + th - 1 - int'(row_idx);
        in_buf = (x >= 0) && (x < bw) && (y >= 0) && (y < bh);
        opaque = !transparent_mode || (texel != '0);
        row_end = int'(row_idx) >= th - 1;
        col_end = int'(col_idx) >= tw - 1;
        p.write_enable  = in_buf && opaque;
        p.write_address = p.write_enable ? ADDR_W'(y * bw + x) : '0;
        p.pixel_value   = texel;
        p.last_texel    = row_end && col_end;
        if (row_end)
        begin
            row_idx = '0;
            col_idx = col_end ? '0 : col_idx + 10'd1;
        end
        else
        begin
            row_idx = row_idx + 10'd1;
        end
        return p;
    endfunction

    // Leaves valid high after the transaction so that back-to-back texels need no gap.
    task automatic send_texel(input logic [TEXEL_W-1:0] value);
        pixel_t p;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            texels.valid <= 1'b0;
            texels.texel <= TEXEL_W'($urandom);
            @(posedge clk);
        end
        texels.valid <= 1'b1;
        texels.texel <= value;
        @(posedge clk);
        while (!texels.ready)
            @(posedge clk);
        p = blit_texel(value);
        pending_pixels.push_back(p);
        texels_sent++;
        if (p.write_enable)
            writes_enabled++;
        else
            writes_suppressed++;
        if (p.last_texel)
            textures_done++;
    endtask

    task automatic stop_texels();
        texels.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BUF_WIDTH:   buf_width = data[SIZE_W-1:0];
            REG_BUF_HEIGHT:  buf_height = data[SIZE_W-1:0];
            REG_POS_X:       pos_x = data;
            REG_POS_Y:       pos_y = data;
            REG_TEX_WIDTH:   tex_width = data[SIZE_W-1:0];
            REG_TEX_HEIGHT:  tex_height = data[SIZE_W-1:0];
            REG_TRANSPARENT: transparent_mode = data[0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_buf_size();
        logic [SIZE_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = 11'd1;
            2:       v = 11'd1024;
            3:       v = SIZE_W'($urandom_range(1025, 2047));
            4:       v = SIZE_W'($urandom);
            default: v = SIZE_W'($urandom_range(1, 48));
        endcase
        return {1'($urandom), v};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_tex_size();
        logic [SIZE_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = 11'd1024;
            2:       v = SIZE_W'($urandom_range(1025, 2047));
            3:       v = SIZE_W'($urandom_range(1, 1023));
            default: v = SIZE_W'($urandom_range(1, 8));
        endcase
        return {1'($urandom), v};
    endfunction

    // Mostly places the texture so that it straddles the buffer edges.
    function automatic logic [CFG_DATA_W-1:0] rand_pos(input int span, input int extent);
        case ($urandom_range(0, 9))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'(int'($urandom_range(0, span + extent + 2)) - extent - 1);
        endcase
    endfunction

    task automatic randomise_setting();
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_BUF_WIDTH, rand_buf_size());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_BUF_HEIGHT, rand_buf_size());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_TEX_WIDTH, rand_tex_size());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_TEX_HEIGHT, rand_tex_size());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_POS_X, rand_pos(buf_extent(buf_width), tex_extent(tex_width)));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_POS_Y, rand_pos(buf_extent(buf_height), tex_extent(tex_height)));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_TRANSPARENT, CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : pixel_checker
        pixel_t want;
        if (rst_n && pixels.valid && pixels.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel transaction with no texel outstanding");
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                compare_field("write_enable", want.write_enable, pixels.write_enable);
                compare_field("write_address", want.write_address, pixels.write_address);
                compare_field("pixel_value", want.pixel_value, pixels.pixel_value);
                compare_field("last_texel", want.last_texel, pixels.last_texel);
            end
        end
        pixels.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((texels.valid && texels.ready) || (pixels.valid && pixels.ready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register defaults: a 1x1 texture at the origin of a 320x200 buffer.
    task automatic test_reset_defaults();
        send_texel(8'h00);
        send_texel(8'hFF);
        send_texel(8'h5A);
        stop_texels();
    endtask

    task automatic test_transparency();
        write_reg(REG_TRANSPARENT, 12'h001);
        send_texel(8'h00);
        send_texel(8'hFF);
        send_texel(8'h00);
        send_texel(8'h01);
        stop_texels();
        write_reg(REG_TRANSPARENT, 12'hFFE);
    endtask

    // A 3x3 texture over a 1x1 buffer, offset so that only the centre texel lands inside.
    task automatic test_clipping();
        write_reg(REG_BUF_WIDTH, 12'd1);
        write_reg(REG_BUF_HEIGHT, 12'd1);
        write_reg(REG_TEX_WIDTH, 12'd3);
        write_reg(REG_TEX_HEIGHT, 12'd3);
        write_reg(REG_POS_X, 12'hFFF);
        write_reg(REG_POS_Y, 12'hFFF);
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                send_texel(TEXEL_W'(c * 16 + r + 1));
        stop_texels();
    endtask

    task automatic test_size_extremes();
        // A buffer of zero width has no inside.
        write_reg(REG_BUF_WIDTH, 12'd0);
        write_reg(REG_TEX_WIDTH, 12'd1);
        write_reg(REG_TEX_HEIGHT, 12'd1);
        write_reg(REG_POS_X, 12'd0);
        write_reg(REG_POS_Y, 12'd0);
        send_texel(8'h77);
        stop_texels();

        // Oversized buffer and zero texture size, hitting the highest address.
        write_reg(REG_BUF_WIDTH, 12'hFFF);
        write_reg(REG_BUF_HEIGHT, 12'h7FF);
        write_reg(REG_TEX_WIDTH, 12'd0);
        write_reg(REG_TEX_HEIGHT, 12'd0);
        write_reg(REG_POS_X, 12'h3FF);
        write_reg(REG_POS_Y, 12'h3FF);
        send_texel(8'hC3);
        stop_texels();
        write_reg(REG_POS_X, 12'h7FF);
        send_texel(8'h3C);
        stop_texels();
        write_reg(REG_POS_X, 12'h800);
        send_texel(8'h81);
        stop_texels();

        // Oversized texture, then shrunk while the walk is part way down a column.
        write_reg(REG_POS_X, 12'd0);
        write_reg(REG_POS_Y, 12'd0);
        write_reg(REG_TEX_WIDTH, 12'h7FF);
        write_reg(REG_TEX_HEIGHT, 12'h7FF);
        send_texel(8'h11);
        send_texel(8'h22);
        send_texel(8'h33);
        stop_texels();
        write_reg(REG_TEX_HEIGHT, 12'd2);
        send_texel(8'h44);
        send_texel(8'h55);
        stop_texels();
        write_reg(REG_TEX_WIDTH, 12'd1);
        send_texel(8'h66);
        send_texel(8'h99);
        stop_texels();
        write_reg(REG_UNUSED, 12'hABC);
    endtask

    // Mostly whole textures, with some partial runs that leave the walk mid-texture
    // for the next setting to pick up.
    task automatic test_random_textures(input int src_pct, input int snk_pct);
        int sent_here;
        int n;
        int area;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent_here = 0;
        while (sent_here < RANDOM_ITEMS_PER_MODE)
        begin
            randomise_setting();
            area = tex_extent(tex_width) * tex_extent(tex_height);
            if (area <= 96 && $urandom_range(0, 5) != 0)
                n = area * $urandom_range(1, 3);
            else
                n = $urandom_range(1, 40);
            repeat (n)
                send_texel((transparent_mode && $urandom_range(0, 3) == 0) ?
                           '0 : TEXEL_W'($urandom));
            stop_texels();
            sent_here += n;
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        texels.valid  <= 1'b0;
        texels.texel  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_transparency();
        test_clipping();
        test_size_extremes();
        test_random_textures(32, 62);
        test_random_textures(62, 32);
        test_random_textures(0, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d pixel transactions never arrived", pending_pixels.size());
            errors++;
        end

        $display("Blitted %0d texels (%0d complete textures) under %0d register settings.",
                 texels_sent, textures_done, settings_used);
        $display("Of these, %0d pixels were written and %0d clipped or transparent.",
                 writes_enabled, writes_suppressed);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_if.sv
hw/rtl/ctb_walk.sv
hw/rtl/ctb_pixel.sv
hw/rtl/clipped_transparent_blit_top.sv
dv/testbench.sv
